### rtl/core/xsr_pkg.sv
`timescale 1ns / 1ps

package xsr_pkg;

  localparam int unsigned WordW   = 64;
  localparam int unsigned NumWords = 4;
  localparam int unsigned InDataW = 2 * WordW;
  localparam int unsigned CntW    = $clog2(WordW);

  localparam logic [WordW-1:0] SmGolden = 64'h9E3779B97F4A7C15;
  localparam logic [WordW-1:0] SmMulA   = 64'hBF58476D1CE4E5B9;
  localparam logic [WordW-1:0] SmMulB   = 64'h94D049BB133111EB;

  localparam int unsigned SmShiftA = 30;
  localparam int unsigned SmShiftB = 27;
  localparam int unsigned SmShiftC = 31;
  localparam int unsigned XoShiftT = 17;
  localparam int unsigned XoRotOut = 7;
  localparam int unsigned XoRotW3  = 45;

  localparam logic CmdDraw   = 1'b0;
  localparam logic CmdReseed = 1'b1;

endpackage

### rtl/core/xoshiro256ss_bounded_prng.sv
`timescale 1ns / 1ps

// xoshiro256** generator with splitmix64 reseeding and a bounded draw.
//
// Input stream: tuser carries the command (draw or reseed), tdata carries
// seed_value and bound. Output stream: one 64-bit result per input transaction.
// One transaction is worked on at a time; the input is ready again once the
// result has been moved into the output register.
//
// Draw, nonzero bound: the states ST_DR_MUL5 and ST_DR_MUL9 build the
// scrambled output and step the state, then a restoring remainder loop
// takes one quotient bit per cycle over all 64 bits of the scrambled value.
// Draw, zero bound: result 0, state untouched.
// Reseed: result 0. Each of the four splitmix64 steps runs two
// shift-and-add multiplies by constants, one multiplier bit per cycle.
// The next transaction is accepted in the cycle after the result is registered.
//
// Reset clears the generator words to zero, so draws return 0 until a reseed.
// If the receiver stalls, the finished result waits in the output register;
// a following transaction may be accepted and run, but cannot finish until
// the output register is free.
module xoshiro256ss_bounded_prng (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [xsr_pkg::InDataW-1:0]    s_axis_tdata_i,  // seed_value, bound
  input  logic                           s_axis_tuser_i,  // cmd
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [xsr_pkg::WordW-1:0]      m_axis_tdata_o   // value
);

  import xsr_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SM_ADD,
    ST_SM_MUL_A,
    ST_SM_MIX,
    ST_SM_MUL_B,
    ST_SM_STORE,
    ST_DR_MUL5,
    ST_DR_MUL9,
    ST_DR_MOD,
    ST_DONE
  } state_e;

  localparam logic [CntW-1:0] LastBit = CntW'(WordW - 1);

  state_e                  state_q;
  logic [WordW-1:0]        words_q [NumWords];
  logic [WordW-1:0]        seed_q;
  logic [WordW-1:0]        bound_q;
  logic [WordW-1:0]        acc_q;
  logic [WordW-1:0]        mcand_q;
  logic [WordW-1:0]        kbits_q;
  logic [WordW:0]          rem_q;
  logic [CntW-1:0]         cnt_q;
  logic [1:0]              idx_q;
  logic                    m_valid_q;
  logic [WordW-1:0]        m_data_q;

  logic                    s_fire;
  logic                    m_fire;
  logic [WordW-1:0]        in_seed;
  logic [WordW-1:0]        in_bound;
  logic [WordW-1:0]        sm_sum;
  logic [WordW-1:0]        w1_x5;
  logic [WordW-1:0]        scr_out;
  logic [WordW-1:0]        w3_mix;
  logic [WordW:0]          rem_sh;
  logic                    rem_ge;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_fire          = m_valid_q && m_axis_tready_i;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  assign in_seed  = s_axis_tdata_i[WordW-1:0];
  assign in_bound = s_axis_tdata_i[InDataW-1:WordW];

  assign sm_sum  = seed_q + SmGolden;
  assign w1_x5   = words_q[1] + (words_q[1] << 2);
  assign scr_out = acc_q + (acc_q << 3);
  assign w3_mix  = words_q[3] ^ words_q[1];
  assign rem_sh  = {rem_q[WordW-1:0], mcand_q[WordW-1]};
  assign rem_ge  = (rem_sh >= {1'b0, bound_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      seed_q    <= '0;
      bound_q   <= '0;
      acc_q     <= '0;
      mcand_q   <= '0;
      kbits_q   <= '0;
      rem_q     <= '0;
      cnt_q     <= '0;
      idx_q     <= '0;
      for (int i = 0; i < NumWords; i++) begin
        words_q[i] <= '0;
      end
    end else begin
      if (m_fire && state_q != ST_DONE) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_fire) begin
            seed_q  <= in_seed;
            bound_q <= in_bound;
            idx_q   <= '0;
            rem_q   <= '0;
            if (s_axis_tuser_i == CmdReseed) begin
              state_q <= ST_SM_ADD;
            end else if (in_bound != '0) begin
              state_q <= ST_DR_MUL5;
            end else begin
              state_q <= ST_DONE;
            end
          end
        end
        ST_SM_ADD: begin
          seed_q  <= sm_sum;
          mcand_q <= sm_sum ^ (sm_sum >> SmShiftA);
          kbits_q <= SmMulA;
          acc_q   <= '0;
          cnt_q   <= '0;
          state_q <= ST_SM_MUL_A;
        end
        ST_SM_MUL_A, ST_SM_MUL_B: begin
          if (kbits_q[0]) begin
            acc_q <= acc_q + mcand_q;
          end
          mcand_q <= mcand_q << 1;
          kbits_q <= kbits_q >> 1;
          cnt_q   <= cnt_q + 1'b1;
          if (cnt_q == LastBit) begin
            state_q <= (state_q == ST_SM_MUL_A) ? ST_SM_MIX : ST_SM_STORE;
          end
        end
        ST_SM_MIX: begin
          mcand_q <= acc_q ^ (acc_q >> SmShiftB);
          kbits_q <= SmMulB;
          acc_q   <= '0;
          cnt_q   <= '0;
          state_q <= ST_SM_MUL_B;
        end
        ST_SM_STORE: begin
          words_q[idx_q] <= acc_q ^ (acc_q >> SmShiftC);
          idx_q          <= idx_q + 1'b1;
          state_q        <= (idx_q == 2'd3) ? ST_DONE : ST_SM_ADD;
        end
        ST_DR_MUL5: begin
          acc_q   <= {w1_x5[WordW-1-XoRotOut:0], w1_x5[WordW-1:WordW-XoRotOut]};
          state_q <= ST_DR_MUL9;
        end
        ST_DR_MUL9: begin
          mcand_q    <= scr_out;
          cnt_q      <= '0;
          words_q[0] <= words_q[0] ^ w3_mix;
          words_q[1] <= words_q[1] ^ words_q[2] ^ words_q[0];
          words_q[2] <= words_q[2] ^ words_q[0] ^ (words_q[1] << XoShiftT);
          words_q[3] <= {w3_mix[WordW-1-XoRotW3:0], w3_mix[WordW-1:WordW-XoRotW3]};
          state_q    <= ST_DR_MOD;
        end
        ST_DR_MOD: begin
          rem_q   <= rem_ge ? (rem_sh - {1'b0, bound_q}) : rem_sh;
          mcand_q <= mcand_q << 1;
          cnt_q   <= cnt_q + 1'b1;
          if (cnt_q == LastBit) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_valid_q || m_axis_tready_i) begin
            m_valid_q <= 1'b1;
            m_data_q  <= rem_q[WordW-1:0];
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> !s_axis_tready_o)
    else $error("input ready straight after an accepted transaction");

  a_rem_below_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DR_MOD) |-> (rem_q < {1'b0, bound_q}))
    else $error("partial remainder not below bound");

  a_mod_bound_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DR_MOD) |-> (bound_q != '0))
    else $error("remainder loop entered with zero bound");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && m_valid_q && !m_axis_tready_i) |=>
      (state_q == ST_DONE && m_valid_q))
    else $error("result overwrote a stalled output");

endmodule

### tb/xsr_checker.sv
`timescale 1ns / 1ps

module xsr_checker
  import xsr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  input  logic               s_tready_i,
  input  logic [InDataW-1:0] s_tdata_i,   // seed_value, bound
  input  logic               s_tuser_i,   // cmd
  input  logic               m_tvalid_i,
  input  logic               m_tready_i,
  input  logic [WordW-1:0]   m_tdata_i,   // value
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 reseeds_o,
  output int                 draws_o,
  output int                 zero_bounds_o
);

  logic [WordW-1:0] gen_state [NumWords];
  logic [WordW-1:0] owed_values [$];

  function automatic logic [WordW-1:0] rot_left(logic [WordW-1:0] v, int unsigned n);
    return (v << n) | (v >> (WordW - n));
  endfunction

  task automatic reseed_state(input logic [WordW-1:0] seed);
    logic [WordW-1:0] acc;
    logic [WordW-1:0] z;
    acc = seed;
    for (int i = 0; i < NumWords; i++) begin
      acc = acc + SmGolden;
      z = acc;
      z = (z ^ (z >> SmShiftA)) * SmMulA;
      z = (z ^ (z >> SmShiftB)) * SmMulB;
      gen_state[i] = z ^ (z >> SmShiftC);
    end
  endtask

  task automatic step_state(output logic [WordW-1:0] scrambled);
    logic [WordW-1:0] t;
    scrambled = rot_left(gen_state[1] * 64'd5, XoRotOut) * 64'd9;
    t = gen_state[1] << XoShiftT;
    gen_state[2] = gen_state[2] ^ gen_state[0];
    gen_state[3] = gen_state[3] ^ gen_state[1];
    gen_state[1] = gen_state[1] ^ gen_state[2];
    gen_state[0] = gen_state[0] ^ gen_state[3];
    gen_state[2] = gen_state[2] ^ t;
    gen_state[3] = rot_left(gen_state[3], XoRotW3);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [WordW-1:0] seed;
    logic [WordW-1:0] bound;
    logic [WordW-1:0] want;
    logic [WordW-1:0] drawn;
    if (!rst_ni) begin
      for (int i = 0; i < NumWords; i++) gen_state[i] = '0;
      owed_values.delete();
      fail_count_o  = 0;
      pending_o     = 0;
      reseeds_o     = 0;
      draws_o       = 0;
      zero_bounds_o = 0;
    end else begin
      // result side first: it can only belong to an earlier transaction
      if (m_tvalid_i && m_tready_i) begin
        if (owed_values.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, m_tdata_i);
          fail_count_o++;
        end else begin
          want = owed_values.pop_front();
          if (m_tdata_i !== want) begin
            $display("%0t: value wrong, expected %h, got %h", $time, want, m_tdata_i);
            fail_count_o++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        seed  = s_tdata_i[WordW-1:0];
        bound = s_tdata_i[InDataW-1:WordW];
        if (s_tuser_i == CmdReseed) begin
          reseed_state(seed);
          owed_values.push_back('0);
          reseeds_o++;
        end else if (bound == '0) begin
          owed_values.push_back('0);
          zero_bounds_o++;
        end else begin
          step_state(drawn);
          owed_values.push_back(drawn % bound);
          draws_o++;
        end
      end
      pending_o = owed_values.size();
    end
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import xsr_pkg::*;

  localparam int unsigned RandItems  = 1450;
  localparam int unsigned CycleLimit = 4_000_000;

  logic               clk      = 1'b0;
  logic               rst_n    = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [InDataW-1:0] in_data  = '0;   // seed_value, bound
  logic               in_cmd   = CmdDraw;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [WordW-1:0]   out_data;        // value

  int fail_count, pending, reseeds, draws, zero_bounds;
  int unsigned cycles = 0;
  int stall_left = 0;
  bit tx_calm = 1'b0;
  wire rx_calm = cycles[12] & cycles[11];

  always #1 clk = ~clk;

  xoshiro256ss_bounded_prng u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_data),
    .s_axis_tuser_i  (in_cmd),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data)
  );

  xsr_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_tvalid_i    (in_valid),
    .s_tready_i    (in_ready),
    .s_tdata_i     (in_data),
    .s_tuser_i     (in_cmd),
    .m_tvalid_i    (out_valid),
    .m_tready_i    (out_ready),
    .m_tdata_i     (out_data),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .reseeds_o     (reseeds),
    .draws_o       (draws),
    .zero_bounds_o (zero_bounds)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 3);
    if (r < 18) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [WordW-1:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [WordW-1:0] pick_bound();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return WordW'($urandom_range(1, 16));
      3:       return WordW'(1) << $urandom_range(0, 63);
      4:       return rand_word() >> $urandom_range(0, 63);
      default: return rand_word();
    endcase
  endfunction

  function automatic logic [WordW-1:0] pick_seed();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return WordW'($urandom_range(0, 255));
      default: return rand_word();
    endcase
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("xoshiro256ss_bounded_prng: mismatch");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!rx_calm && $urandom_range(0, 3) == 0) stall_left <= gap_len();
    end
  end

  task automatic send_item(input logic cmd, input logic [WordW-1:0] seed,
                           input logic [WordW-1:0] bound);
    int gap;
    gap = (tx_calm || $urandom_range(0, 2) != 0) ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_data  <= {bound, seed};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int r;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // all-zero state before any reseed
    send_item(CmdDraw, '0, 64'd1);
    send_item(CmdDraw, '1, '1);
    send_item(CmdDraw, rand_word(), rand_word());
    send_item(CmdDraw, '0, '0);
    send_item(CmdReseed, '0, '1);
    send_item(CmdDraw, '1, '1);
    send_item(CmdDraw, '0, 64'd1);
    send_item(CmdDraw, '0, 64'd2);
    send_item(CmdDraw, '0, 64'h8000_0000_0000_0000);
    send_item(CmdDraw, '1, '0);
    send_item(CmdDraw, rand_word(), rand_word());
    send_item(CmdReseed, '1, '0);
    send_item(CmdDraw, '0, '1);
    send_item(CmdDraw, '0, 64'd3);
    send_item(CmdDraw, '1, '0);
    send_item(CmdDraw, '0, 64'h0000_0001_0000_0000);
    send_item(CmdReseed, rand_word(), rand_word());
    repeat (4) send_item(CmdDraw, rand_word(), rand_word());

    for (int i = 0; i < RandItems; i++) begin
      tx_calm = (i % 200) < 30;
      if (i == RandItems / 3 || i == (2 * RandItems) / 3) begin
        in_valid <= 1'b0;
        drain();
      end
      r = $urandom_range(0, 99);
      if (r < 4) send_item(CmdReseed, pick_seed(), rand_word());
      else send_item(CmdDraw, rand_word(), pick_bound());
    end
    in_valid <= 1'b0;

    drain();
    repeat (80) @(posedge clk);
    $display("covered %0d draws, %0d zero-bound draws and %0d reseeds in %0d cycles",
             draws, zero_bounds, reseeds, cycles);
    $display("with random gaps on the input and random stalls on the output");
    if (fail_count == 0 && pending == 0) begin
      $display("xoshiro256ss_bounded_prng: match");
    end else begin
      $display("xoshiro256ss_bounded_prng: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/xsr_pkg.sv
rtl/core/xoshiro256ss_bounded_prng.sv
tb/xsr_checker.sv
tb/tb.sv
